// ===== sv/frtv_pkg.sv =====
package frtv_pkg;

    localparam int ByteW   = 8;
    localparam int OffW    = 7;
    localparam int SizeOutW = 40;
    localparam int OutDataW = 48;

    localparam logic [ByteW-1:0] ChLf     = 8'h0A;
    localparam logic [ByteW-1:0] ChCr     = 8'h0D;
    localparam logic [ByteW-1:0] ChSpace  = 8'h20;
    localparam logic [ByteW-1:0] ChHyphen = 8'h2D;
    localparam logic [ByteW-1:0] ChDigLo  = 8'h30;
    localparam logic [ByteW-1:0] ChDigHi  = 8'h39;
    localparam logic [ByteW-1:0] ChUpLo   = 8'h41;
    localparam logic [ByteW-1:0] ChUpHi   = 8'h5A;

    localparam logic [OffW-1:0] OffTerm1 = 7'd80;
    localparam logic [OffW-1:0] OffTerm2 = 7'd81;

    localparam logic [6:0] LenLf   = 7'd81;
    localparam logic [6:0] LenCrlf = 7'd82;

    typedef enum logic [1:0] {
        ST_VALID      = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_BAD_TERM   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_LF   = 2'd1,
        MODE_CRLF = 2'd2
    } t_mode;

    typedef struct packed {
        logic [SizeOutW-1:0] size;
        t_mode               mode;
        t_status             status;
    } t_result;

endpackage

// ===== sv/frtv_hdr_check.sv =====
module frtv_hdr_check (
    input  logic [frtv_pkg::OffW-1:0]  i_offset,
    input  logic [frtv_pkg::ByteW-1:0] i_byte,
    output logic                       o_ok
);
    import frtv_pkg::*;

    localparam logic [ByteW-1:0] SigText [10] = '{
        8'h48, 8'h45, 8'h41, 8'h44, 8'h45, 8'h52, 8'h20, 8'h20, 8'h20, 8'h20
    };

    logic is_digit;
    logic is_upper;

    assign is_digit = (i_byte >= ChDigLo) && (i_byte <= ChDigHi);
    assign is_upper = (i_byte >= ChUpLo) && (i_byte <= ChUpHi);

    always_comb begin
        o_ok = 1'b1;
        if (i_offset < 7'd10) begin
            o_ok = (i_byte == SigText[i_offset[3:0]]);
        end else if (i_offset == 7'd50 || i_offset == 7'd51 ||
                     i_offset == 7'd57 || i_offset == 7'd58) begin
            o_ok = is_digit;
        end else if (i_offset == 7'd52 || i_offset == 7'd56) begin
            o_ok = (i_byte == ChHyphen);
        end else if (i_offset >= 7'd53 && i_offset <= 7'd55) begin
            o_ok = is_upper;
        end else if ((i_offset >= 7'd59 && i_offset <= 7'd61) ||
                     (i_offset >= 7'd66 && i_offset <= 7'd69)) begin
            o_ok = (i_byte == ChSpace);
        end
    end

endmodule

// ===== sv/frtv_core.sv =====
module frtv_core #(
    parameter int SIZE_BITS = 40
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic [frtv_pkg::ByteW-1:0] i_byte,
    input  logic                       i_start,
    output frtv_pkg::t_result          o_next
);
    import frtv_pkg::*;

    localparam int WideW = (SIZE_BITS > SizeOutW) ? SIZE_BITS : SizeOutW;

    logic [OffW-1:0]      r_off, n_off, cur_off;
    t_mode                r_mode, n_mode, cur_mode;
    t_status              r_verdict, n_verdict, cur_verdict;
    logic [SIZE_BITS-1:0] r_good, n_good, cur_good;
    logic [6:0]           add_len;
    logic [SIZE_BITS:0]   sum;
    logic                 hdr_ok;
    logic [WideW-1:0]     good_wide;

    frtv_hdr_check u_hdr_check (
        .i_offset (cur_off),
        .i_byte   (i_byte),
        .o_ok     (hdr_ok)
    );

    always_comb begin
        cur_off     = i_start ? '0 : r_off;
        cur_mode    = i_start ? MODE_NONE : r_mode;
        cur_verdict = i_start ? ST_VALID : r_verdict;
        cur_good    = i_start ? '0 : r_good;
        n_off       = cur_off;
        n_mode      = cur_mode;
        n_verdict   = cur_verdict;
        add_len     = '0;
        if (cur_verdict == ST_VALID) begin
            if (cur_mode == MODE_NONE) begin
                if (cur_off < OffTerm1) begin
                    if (hdr_ok) begin
                        n_off = cur_off + 7'd1;
                    end else begin
                        n_verdict = ST_BAD_HEADER;
                    end
                end else if (cur_off == OffTerm1) begin
                    if (i_byte == ChLf) begin
                        n_mode  = MODE_LF;
                        add_len = LenLf;
                        n_off   = '0;
                    end else if (i_byte == ChCr) begin
                        n_off = OffTerm2;
                    end else begin
                        n_verdict = ST_BAD_HEADER;
                    end
                end else begin
                    if (i_byte == ChLf) begin
                        n_mode  = MODE_CRLF;
                        add_len = LenCrlf;
                        n_off   = '0;
                    end else begin
                        n_verdict = ST_BAD_HEADER;
                    end
                end
            end else if (cur_off < OffTerm1) begin
                n_off = cur_off + 7'd1;
            end else if (cur_mode == MODE_LF) begin
                if (i_byte == ChLf) begin
                    add_len = LenLf;
                    n_off   = '0;
                end else begin
                    n_verdict = ST_BAD_TERM;
                end
            end else if (cur_off == OffTerm1) begin
                if (i_byte == ChCr) begin
                    n_off = OffTerm2;
                end else begin
                    n_verdict = ST_BAD_TERM;
                end
            end else begin
                if (i_byte == ChLf) begin
                    add_len = LenCrlf;
                    n_off   = '0;
                end else begin
                    n_verdict = ST_BAD_TERM;
                end
            end
        end
        sum    = {1'b0, cur_good} + (SIZE_BITS + 1)'(add_len);
        n_good = sum[SIZE_BITS] ? '1 : sum[SIZE_BITS-1:0];
    end

    assign good_wide     = WideW'(n_good);
    assign o_next.size   = good_wide[SizeOutW-1:0];
    assign o_next.mode   = n_mode;
    assign o_next.status = n_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off     <= '0;
            r_mode    <= MODE_NONE;
            r_verdict <= ST_VALID;
            r_good    <= '0;
        end else if (i_take) begin
            r_off     <= n_off;
            r_mode    <= n_mode;
            r_verdict <= n_verdict;
            r_good    <= n_good;
        end
    end

endmodule

// ===== sv/fixed_record_text_validator.sv =====
// Fixed-record text validator. Takes one byte per item; tuser high marks the
// first byte of a new candidate file. The first 81- or 82-byte record is
// checked as a header line, its terminator (LF or CR LF) fixes the record
// length, and each later record must end the same way. Every input item
// yields one result item carrying the status, line mode and a saturating
// count of bytes in complete valid records, all as they stand after that
// byte. A failure holds until the next start. Throughput is one item per
// clock while m_axis_tready does not stall it; the core state updates per
// taken byte. Each byte passes the input register, then the result register.
module fixed_record_text_validator #(
    parameter int SIZE_BITS = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tuser,  // [0] start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // [1:0] status, [3:2] line_mode,
                                       // [43:4] accepted_size, [47:44] zero
);
    import frtv_pkg::*;

    logic              r_in_valid;
    logic [ByteW-1:0]  r_in_byte;
    logic              r_in_start;
    logic              r_out_valid;
    t_result           r_out;
    t_result           core_next;
    logic              advance;
    logic              take;

    assign advance       = !r_out_valid || m_axis_tready;
    assign take          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    frtv_core #(
        .SIZE_BITS (SIZE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (r_in_byte),
        .i_start (r_in_start),
        .o_next  (core_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= core_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OutDataW - $bits(t_result))'(0), r_out};

endmodule

// ===== sim/fixed_record_text_validator_tb.sv =====
module fixed_record_text_validator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frtv_pkg::*;

    localparam int ItemTarget = 1400;
    localparam int PhaseLen   = 150;
    localparam int IdleLimit  = 3000;
    localparam int DrainWait  = 12;

    typedef enum int {
        F_NONE,
        F_HEADER,
        F_HDR_TERM,
        F_HDR_CR,
        F_REC_TERM,
        F_REC_CR
    } t_fault;

    class t_scoreboard;
        t_result    pending[$];
        logic [6:0] rec_pos;
        t_mode      cur_mode;
        t_status    cur_status;
        logic [39:0] held_bytes;
        int         errors;
        int         items_taken;
        int         results_seen;

        function new();
            restart();
            errors       = 0;
            items_taken  = 0;
            results_seen = 0;
        endfunction

        function void restart();
            rec_pos    = '0;
            cur_mode   = MODE_NONE;
            cur_status = ST_VALID;
            held_bytes = '0;
        endfunction

        static function bit header_byte_ok(logic [6:0] pos, logic [7:0] c);
            logic [79:0] sig;
            int p;
            sig = "HEADER    ";
            p = pos;
            if (p < 10)
                return c == sig[8*(9-p) +: 8];
            if (p == 50 || p == 51 || p == 57 || p == 58)
                return c >= ChDigLo && c <= ChDigHi;
            if (p == 52 || p == 56)
                return c == ChHyphen;
            if (p >= 53 && p <= 55)
                return c >= ChUpLo && c <= ChUpHi;
            if ((p >= 59 && p <= 61) || (p >= 66 && p <= 69))
                return c == ChSpace;
            return 1'b1;
        endfunction

        function void add_bytes(logic [6:0] n);
            logic [40:0] sum;
            sum = {1'b0, held_bytes} + 41'(n);
            held_bytes = sum[40] ? '1 : sum[39:0];
        endfunction

        function void advance(logic [7:0] c);
            if (cur_mode == MODE_NONE) begin
                if (rec_pos < OffTerm1) begin
                    if (!header_byte_ok(rec_pos, c))
                        cur_status = ST_BAD_HEADER;
                    else
                        rec_pos = rec_pos + 7'd1;
                end else if (rec_pos == OffTerm1) begin
                    if (c == ChLf) begin
                        cur_mode = MODE_LF;
                        add_bytes(LenLf);
                        rec_pos = '0;
                    end else if (c == ChCr) begin
                        rec_pos = OffTerm2;
                    end else begin
                        cur_status = ST_BAD_HEADER;
                    end
                end else if (c == ChLf) begin
                    cur_mode = MODE_CRLF;
                    add_bytes(LenCrlf);
                    rec_pos = '0;
                end else begin
                    cur_status = ST_BAD_HEADER;
                end
            end else if (rec_pos < OffTerm1) begin
                rec_pos = rec_pos + 7'd1;
            end else if (cur_mode == MODE_LF) begin
                if (c == ChLf) begin
                    add_bytes(LenLf);
                    rec_pos = '0;
                end else begin
                    cur_status = ST_BAD_TERM;
                end
            end else if (rec_pos == OffTerm1) begin
                if (c == ChCr)
                    rec_pos = OffTerm2;
                else
                    cur_status = ST_BAD_TERM;
            end else if (c == ChLf) begin
                add_bytes(LenCrlf);
                rec_pos = '0;
            end else begin
                cur_status = ST_BAD_TERM;
            end
        endfunction

        function void note_item(logic [7:0] c, logic st);
            t_result r;
            if (st)
                restart();
            if (cur_status == ST_VALID) begin
                advance(c);
                items_taken++;
            end
            r.size   = held_bytes;
            r.mode   = cur_mode;
            r.status = cur_status;
            pending.push_back(r);
        endfunction

        function void check_result(logic [47:0] d);
            t_result want;
            t_result got;
            results_seen++;
            if (pending.size() == 0) begin
                $error("result with no item pending: tdata=%h", d);
                errors++;
                return;
            end
            want = pending.pop_front();
            got  = t_result'(d[43:0]);
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.mode !== want.mode) begin
                $error("line_mode: expected %0d, actual %0d", want.mode, got.mode);
                errors++;
            end
            if (got.size !== want.size) begin
                $error("accepted_size: expected %0d, actual %0d", want.size, got.size);
                errors++;
            end
            if (d[47:44] !== 4'd0) begin
                $error("pad: expected 0, actual %h", d[47:44]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    t_scoreboard sb;
    int phase          = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int bytes_sent     = 0;
    int idle_cycles    = 0;
    int n_files        = 0;
    int n_faulty       = 0;

    fixed_record_text_validator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_item(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic st);
        int nxt;
        nxt = (bytes_sent / PhaseLen) % 4;
        if (nxt != phase) begin
            phase = nxt;
            while (sb.pending.size() != 0) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
            src_idle_pct   = (phase == 1) ? 87 : (phase == 3) ? 32 : 0;
            sink_stall_pct = (phase == 2) ? 87 : (phase == 3) ? 32 : 0;
        end
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= st;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_file(input t_mode term, input int nrec, input t_fault fault,
                             input bit cut);
        logic [7:0] fq[$];
        logic [7:0] c;
        int rec_len, idx, pos, k, last, i;
        rec_len = (term == MODE_LF) ? 81 : 82;
        for (pos = 0; pos < 80; pos++) begin
            do c = 8'($urandom_range(255));
            while (!t_scoreboard::header_byte_ok(7'(pos), c));
            fq.push_back(c);
        end
        for (k = 0; k <= nrec; k++) begin
            if (k > 0)
                for (i = 0; i < 80; i++)
                    fq.push_back(8'($urandom_range(255)));
            if (term == MODE_CRLF)
                fq.push_back(ChCr);
            fq.push_back(ChLf);
        end
        idx = -1;
        k = (nrec > 0) ? $urandom_range(nrec - 1) : 0;
        case (fault)
            F_HEADER: begin
                do pos = $urandom_range(79);
                while (!(pos < 10 || (pos >= 50 && pos <= 61) || (pos >= 66 && pos <= 69)));
                do c = 8'($urandom_range(255));
                while (t_scoreboard::header_byte_ok(7'(pos), c));
                idx = pos;
            end
            F_HDR_TERM: begin
                idx = 80;
                do c = 8'($urandom_range(255)); while (c == ChLf || c == ChCr);
            end
            F_HDR_CR: begin
                idx = 81;
                do c = 8'($urandom_range(255)); while (c == ChLf);
            end
            F_REC_TERM: begin
                idx = rec_len * (k + 1) + 80;
                do c = 8'($urandom_range(255));
                while (c == ((term == MODE_LF) ? ChLf : ChCr));
            end
            F_REC_CR: begin
                idx = rec_len * (k + 1) + 81;
                do c = 8'($urandom_range(255)); while (c == ChLf);
            end
            default: ;
        endcase
        last = fq.size() - 1;
        if (idx >= 0) begin
            fq[idx] = c;
            n_faulty++;
            if (idx + 4 < last)
                last = idx + $urandom_range(4);
        end else if (cut) begin
            last = $urandom_range(last);
        end
        n_files++;
        for (i = 0; i <= last; i++)
            send_byte(fq[i], i == 0);
    endtask

    task automatic send_noise();
        int len, i;
        len = $urandom_range(1, 16);
        for (i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), (i == 0) || ($urandom_range(15) == 0));
    endtask

    task automatic send_random_file();
        int r, nrec;
        t_fault fault;
        t_mode term;
        r = $urandom_range(99);
        term = $urandom_range(1) ? MODE_CRLF : MODE_LF;
        nrec = ($urandom_range(3) == 0) ? $urandom_range(2, 4) : $urandom_range(1);
        if (r >= 82) begin
            send_noise();
        end else begin
            fault = (r < 45) ? F_NONE : t_fault'($urandom_range(1, 5));
            if (fault == F_HDR_CR || fault == F_REC_CR)
                term = MODE_CRLF;
            if ((fault == F_REC_TERM || fault == F_REC_CR) && nrec == 0)
                nrec = 1;
            send_file(term, nrec, fault, $urandom_range(99) < 30);
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_byte("H", 1'b0);
        send_byte("E", 1'b0);
        send_byte("A", 1'b0);
        send_byte("D", 1'b0);
        send_byte("X", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte("H", 1'b1);
        send_byte("E", 1'b0);
        send_byte(ChLf, 1'b0);
        send_byte("H", 1'b1);

        send_file(MODE_LF, 1, F_NONE, 1'b0);
        send_file(MODE_CRLF, 1, F_NONE, 1'b0);
        send_file(MODE_CRLF, 0, F_HDR_CR, 1'b0);
        send_file(MODE_LF, 0, F_HDR_TERM, 1'b0);
        send_file(MODE_CRLF, 0, F_HDR_TERM, 1'b0);
        send_file(MODE_LF, 1, F_REC_TERM, 1'b0);
        send_file(MODE_CRLF, 1, F_REC_TERM, 1'b0);
        send_file(MODE_CRLF, 2, F_REC_CR, 1'b0);
        send_file(MODE_LF, 0, F_HEADER, 1'b0);

        while (bytes_sent < ItemTarget)
            send_random_file();

        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);

        $display("summary: %0d bytes sent in %0d candidate files (%0d with a fault) plus noise,",
                 bytes_sent, n_files, n_faulty);
        $display("summary: %0d results checked across all idle and stall phases, %0d mismatches",
                 sb.results_seen, sb.errors);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
sv/frtv_pkg.sv
sv/frtv_hdr_check.sv
sv/frtv_core.sv
sv/fixed_record_text_validator.sv
sim/fixed_record_text_validator_tb.sv
